// File: rtl/sorted_sparse_accumulate_table_assert.svh
// assertion macros used by the checker file
`ifndef SORTED_SPARSE_ACCUMULATE_TABLE_ASSERT_SVH
`define SORTED_SPARSE_ACCUMULATE_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define SSAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is active
`define SSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/ssat_pkg.sv
// ----------------------------------------------------------------------------
// ssat_pkg
// Shared constants, codes and types of the sorted sparse accumulate table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssat_pkg;

    // table geometry and field widths
    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = 8;
    localparam int KIND_BITS  = 2;
    localparam int THR_BITS   = 31;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int MEM_BITS   = KEY_BITS + VALUE_BITS;

    // stream word layout
    localparam int IN_FIELD_BITS   = KEY_BITS + SLOT_BITS + VALUE_BITS;
    localparam int IN_DATA_BITS    = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_VALUE_LSB   = KEY_BITS;
    localparam int OUT_FOUND_BIT   = KEY_BITS + VALUE_BITS;
    localparam int OUT_COUNT_LSB   = OUT_FOUND_BIT + 1;
    localparam int OUT_FIELD_BITS  = OUT_COUNT_LSB + COUNT_BITS;
    localparam int OUT_DATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // item kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_ACC    = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_SLOT   = 2'd2,
        KIND_PRUNE  = 2'd3
    } kind_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_DECIDE,
        ST_SHIFT,
        ST_SHIFT_LAST,
        ST_INSERT,
        ST_SLOT_RD,
        ST_SLOT_DATA,
        ST_PRUNE,
        ST_RESP
    } state_t;

    // one input item
    typedef struct packed {
        kind_t                  kind;
        logic [KEY_BITS-1:0]    key;
        logic [SLOT_BITS-1:0]   slot;
        logic [VALUE_BITS-1:0]  value;
    } item_t;

    // one result item
    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
        logic                   found;
        logic [COUNT_BITS-1:0]  count;
        logic                   status;
    } res_t;

    // table memory access of one cycle
    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_BITS-1:0]   wr_addr;
        logic [MEM_BITS-1:0]    wr_data;
        logic [ADDR_BITS-1:0]   rd_addr;
    } ram_req_t;

endpackage

// File: rtl/ssat_ram.sv
// ----------------------------------------------------------------------------
// ssat_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssat_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ssat_ctrl.sv
// ----------------------------------------------------------------------------
// ssat_ctrl
// Sequencer: binary search, shift-insert, slot read and prune over the RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssat_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ssat_pkg::item_t                in_item,
    input  logic [ssat_pkg::THR_BITS-1:0]  threshold,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ssat_pkg::res_t                 res,
    output ssat_pkg::ram_req_t             ram_req,
    input  logic [ssat_pkg::MEM_BITS-1:0]  ram_rd_data
);

    import ssat_pkg::*;

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [COUNT_BITS-1:0]  lo_reg, lo_next;
    logic [COUNT_BITS-1:0]  hi_reg, hi_next;
    logic                   hit_reg, hit_next;
    logic [VALUE_BITS-1:0]  hit_val_reg, hit_val_next;
    logic [COUNT_BITS-1:0]  src_reg, src_next;
    logic [ADDR_BITS-1:0]   wr_addr_reg, wr_addr_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_BITS-1:0]  w_reg, w_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    res_t                   res_reg, res_next;

    logic [COUNT_BITS:0]    mid_sum;
    logic [COUNT_BITS-1:0]  mid;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VALUE_BITS-1:0]  rd_val;
    logic [VALUE_BITS-1:0]  rd_mag;
    logic                   rd_keep;
    logic [VALUE_BITS-1:0]  acc_sum;

    // split the read word, probe midpoint, prune test
    assign rd_key  = ram_rd_data[MEM_BITS-1:VALUE_BITS];
    assign rd_val  = ram_rd_data[VALUE_BITS-1:0];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[COUNT_BITS:1];
    assign rd_mag  = rd_val[VALUE_BITS-1] ? (~rd_val + 1'b1) : rd_val;
    assign rd_keep = 64'(rd_mag) > 64'(threshold);
    assign acc_sum = hit_val_reg + item_reg.value;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        hit_reg     <= hit_next;
        hit_val_reg <= hit_val_next;
        src_reg     <= src_next;
        wr_addr_reg <= wr_addr_next;
        w_reg       <= w_next;
        res_reg     <= res_next;
    end

    // next state and memory access
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        hit_next     = hit_reg;
        hit_val_next = hit_val_reg;
        src_next     = src_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        w_next       = w_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        ram_req      = '0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_item;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    hit_next  = 1'b0;
                    src_next  = '0;
                    w_next    = '0;
                    pend_next = 1'b0;
                    case (in_item.kind)
                        KIND_ACC, KIND_LOOKUP: state_next = ST_PROBE;
                        KIND_SLOT:             state_next = ST_SLOT_RD;
                        KIND_PRUNE:            state_next = ST_PRUNE;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end

            // issue a read at the midpoint of the open range
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_req.rd_addr = mid[ADDR_BITS-1:0];
                    state_next      = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end

            // narrow the range toward the lower bound of the key
            ST_COMPARE:
            begin
                if (rd_key < item_reg.key)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                if (rd_key == item_reg.key)
                begin
                    hit_next     = 1'b1;
                    hit_val_next = rd_val;
                end
                state_next = ST_PROBE;
            end

            // lo holds the sorted position of the key
            ST_DECIDE:
            begin
                res_next.key    = item_reg.key;
                res_next.count  = count_reg;
                res_next.status = 1'b0;
                res_next.found  = hit_reg;
                res_next.value  = '0;
                state_next      = ST_RESP;
                if (item_reg.kind == KIND_LOOKUP)
                begin
                    res_next.value = hit_reg ? hit_val_reg : '0;
                end
                else if (hit_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = lo_reg[ADDR_BITS-1:0];
                    ram_req.wr_data = {item_reg.key, acc_sum};
                    res_next.value  = acc_sum;
                end
                else if (count_reg == COUNT_BITS'(CAPACITY))
                begin
                    res_next.status = 1'b1;
                end
                else if (count_reg == lo_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    src_next   = count_reg - 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end

            // move entries up one slot, top down, one per cycle
            ST_SHIFT:
            begin
                ram_req.rd_addr = src_reg[ADDR_BITS-1:0];
                if (pend_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = wr_addr_reg;
                    ram_req.wr_data = ram_rd_data;
                end
                pend_next    = 1'b1;
                wr_addr_next = src_reg[ADDR_BITS-1:0] + 1'b1;
                src_next     = src_reg - 1'b1;
                if (src_reg == lo_reg)
                begin
                    state_next = ST_SHIFT_LAST;
                end
            end

            ST_SHIFT_LAST:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = wr_addr_reg;
                ram_req.wr_data = ram_rd_data;
                pend_next       = 1'b0;
                state_next      = ST_INSERT;
            end

            // write the new pair into the freed slot
            ST_INSERT:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = lo_reg[ADDR_BITS-1:0];
                ram_req.wr_data = {item_reg.key, item_reg.value};
                count_next      = count_reg + 1'b1;
                res_next.key    = item_reg.key;
                res_next.value  = item_reg.value;
                res_next.found  = 1'b0;
                res_next.count  = count_reg + 1'b1;
                res_next.status = 1'b0;
                state_next      = ST_RESP;
            end

            ST_SLOT_RD:
            begin
                if (32'(item_reg.slot) < 32'(count_reg))
                begin
                    ram_req.rd_addr = ADDR_BITS'(item_reg.slot);
                    state_next      = ST_SLOT_DATA;
                end
                else
                begin
                    res_next   = '0;
                    res_next.count = count_reg;
                    state_next = ST_RESP;
                end
            end

            ST_SLOT_DATA:
            begin
                res_next.key    = rd_key;
                res_next.value  = rd_val;
                res_next.found  = 1'b1;
                res_next.count  = count_reg;
                res_next.status = 1'b0;
                state_next      = ST_RESP;
            end

            // stream reads up, write back kept entries at the compacted index
            ST_PRUNE:
            begin
                if (src_reg < count_reg)
                begin
                    ram_req.rd_addr = src_reg[ADDR_BITS-1:0];
                    src_next        = src_reg + 1'b1;
                    pend_next       = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && rd_keep)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = w_reg[ADDR_BITS-1:0];
                    ram_req.wr_data = ram_rd_data;
                    w_next          = w_reg + 1'b1;
                end
                if (!(src_reg < count_reg) && !pend_reg)
                begin
                    count_next     = w_reg;
                    res_next       = '0;
                    res_next.count = w_reg;
                    state_next     = ST_RESP;
                end
            end

            // hand the result to the output register
            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// File: rtl/sorted_sparse_accumulate_table.sv
// ----------------------------------------------------------------------------
// sorted_sparse_accumulate_table
// Sparse vector held as (key, value) pairs sorted by key in one RAM.
//
//   channel   direction  handshake                      word
//   s_axis    in         s_axis_tvalid / s_axis_tready  item: key, slot, value_in; kind in tuser
//   m_axis    out        m_axis_tvalid / m_axis_tready  result; status in tuser
//   cfg       in         cfg_valid / cfg_ready          prune_threshold
//
// Work per item (n = entries, p = insert position):
//   search: b <= ceil(log2(n+1)) probes, one RAM read per probe
//   lookup, accumulate hit or dropped insert: search, then the result
//   accumulate insert: search, shift of n - p entries (none when p = n), one entry a cycle, then the insert write
//   read slot: one RAM read if slot < n; prune: one read a cycle, each kept entry written back
// Reset clears the entry count and the handshakes; the RAM is not cleared.
// One item is in work at a time; the next is taken while a result waits in the
// output register, and m_axis_tready low stalls the sequencer only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_sparse_accumulate_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key, slot, value_in
    input  logic [ssat_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // kind
    input  logic [ssat_pkg::KIND_BITS-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // key_out, value_out, found, entry_count_out, zero fill
    output logic [ssat_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // status
    output logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssat_pkg::THR_BITS-1:0]       cfg_data
);

    import ssat_pkg::*;

    item_t                  in_item;
    logic                   res_valid;
    logic                   res_ready;
    res_t                   res;
    ram_req_t               ram_req;
    logic [MEM_BITS-1:0]    ram_rd_data;
    logic [THR_BITS-1:0]    thr_reg;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg;

    // unpack the input word
    assign in_item.kind  = kind_t'(s_axis_tuser);
    assign in_item.key   = s_axis_tdata[KEY_BITS-1:0];
    assign in_item.slot  = s_axis_tdata[KEY_BITS +: SLOT_BITS];
    assign in_item.value = s_axis_tdata[KEY_BITS+SLOT_BITS +: VALUE_BITS];

    // prune threshold register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // output register between sequencer and result stream
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    // pack the result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_res_reg.count, out_res_reg.found,
                                           out_res_reg.value, out_res_reg.key});
    assign m_axis_tuser  = out_res_reg.status;

    // sequencer
    ssat_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .threshold   (thr_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    // table of (key, value) pairs
    ssat_ram #(
        .WIDTH (MEM_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// File: rtl/ssat_checker.sv
// ----------------------------------------------------------------------------
// ssat_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_sparse_accumulate_table_assert.svh"

module ssat_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ssat_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic [0:0]                          m_axis_tuser
);

    import ssat_pkg::*;

    logic [COUNT_BITS-1:0]     chk_count;
    logic [VALUE_BITS-1:0]     chk_value;
    logic                      chk_found;
    logic                      chk_stall;
    logic                      chk_drop;
    logic [OUT_DATA_BITS:0]    chk_word;

    // result fields as seen on the port
    assign chk_count = m_axis_tdata[OUT_COUNT_LSB +: COUNT_BITS];
    assign chk_value = m_axis_tdata[OUT_VALUE_LSB +: VALUE_BITS];
    assign chk_found = m_axis_tdata[OUT_FOUND_BIT];
    assign chk_stall = m_axis_tvalid && !m_axis_tready;
    assign chk_drop  = m_axis_tvalid && m_axis_tuser[0];
    assign chk_word  = {m_axis_tuser, m_axis_tdata};

    // a stalled result holds its word
    `SSAT_ASSERT_NEXT(a_out_hold, clk, rst_n, chk_stall, m_axis_tvalid && $stable(chk_word))

    // a dropped insert only happens on a full table
    `SSAT_ASSERT_NOW(a_drop_full, clk, rst_n, chk_drop, chk_count == COUNT_BITS'(CAPACITY))

    // a dropped insert reports nothing found and zero value
    `SSAT_ASSERT_NOW(a_drop_empty, clk, rst_n, chk_drop, !chk_found && (chk_value == '0))

    // a found entry implies a non-empty table
    `SSAT_ASSERT_NOW(a_found_count, clk, rst_n, m_axis_tvalid && chk_found, chk_count != '0)

endmodule

bind sorted_sparse_accumulate_table ssat_checker u_checker (.*);
